@@ hw/rtl/prl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package prl_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_READ  = 2'd1,
    FN_CLEAR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SPAN  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] color_number;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic        ramp_before;
    logic [7:0]  read_index;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [8:0]  cell_count;
    logic        entry_valid;
    logic [7:0]  entry_pixel;
    logic [15:0] entry_red;
    logic [15:0] entry_green;
    logic [15:0] entry_blue;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  pixel;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } entry_t;

  // result of one compare-and-subtract step against the span
  typedef struct packed {
    logic       ge;
    logic [8:0] rest;
  } step_t;

endpackage

`default_nettype wire

@@ hw/rtl/prl_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prl_step (
  input  wire logic [8:0]     x,
  input  wire logic [7:0]     span,
  output prl_pkg::step_t      res
);

  logic [8:0] span_w;

  assign span_w   = {1'b0, span};
  assign res.ge   = (x >= span_w);
  assign res.rest = res.ge ? (x - span_w) : x;

endmodule

`default_nettype wire

@@ hw/rtl/prl_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prl_table #(
  parameter int DEPTH = prl_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire prl_pkg::entry_t   wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output prl_pkg::entry_t        rd_data
);

  prl_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/palette_ramp_loader_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake            payload
// cmd      in   cmd_valid/cmd_stall  prl_pkg::cmd_t
// rsp      out  rsp_valid/rsp_stall  prl_pkg::rsp_t
//
// One command at a time; cmd_stall is high from acceptance until the result
// is parked in the output register, so a result may wait while the next
// command is taken. In a ramped add every divide bit and every per-channel
// interpolation step goes through the single compare-and-subtract unit.
// Synchronous reset empties the table count and zeroes the previous point;
// table contents stay as they are.

module palette_ramp_loader_unit #(
  parameter int TABLE_DEPTH = prl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire prl_pkg::cmd_t  cmd,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output prl_pkg::rsp_t       rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (CW > 9) ? CW : 9;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DIV    = 7'b0000010,
    S_ACC    = 7'b0000100,
    S_FILL   = 7'b0001000,
    S_APPEND = 7'b0010000,
    S_READ   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  logic [CW-1:0]     cells;
  logic [7:0]        prev_pixel;
  logic [15:0]       prev_r;
  logic [15:0]       prev_g;
  logic [15:0]       prev_b;
  logic [7:0]        last_pixel;

  prl_pkg::entry_t   pt;
  prl_pkg::status_t  st;
  logic              dropped;
  logic              rd_valid;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        span;
  logic [7:0]        k;
  logic [1:0]        lane;
  logic [3:0]        bitcnt;
  logic [15:0]       dq;
  logic [7:0]        rem;

  logic [15:0]       base [4];
  logic [15:0]       mag [4];
  logic              neg [4];
  logic [15:0]       q0 [4];
  logic [7:0]        r0 [4];
  logic [15:0]       accq [4];
  logic [7:0]        accr [4];

  logic              accept;
  logic              rsp_load;
  logic              full;
  logic [7:0]        px_in;
  logic [IW-1:0]     cells_w;
  logic [IW-1:0]     idx_w;
  logic              ramp_ok;
  logic [15:0]       set_a [4];
  logic [15:0]       set_b [4];
  logic [8:0]        step_x;
  prl_pkg::step_t    step_res;
  logic [15:0]       lane_val [4];
  prl_pkg::entry_t   fill_entry;
  logic              push_en;
  prl_pkg::entry_t   push_entry;
  prl_pkg::entry_t   rd_data;
  prl_pkg::rsp_t     rsp_next;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);
  assign full      = (cells == CW'(TABLE_DEPTH));
  assign px_in     = cmd.color_number[7:0];
  assign cells_w   = IW'(cells);
  assign idx_w     = IW'(cmd.read_index);
  assign ramp_ok   = cmd.ramp_before && (cells != '0) && (px_in > last_pixel);

  assign set_a[0] = {8'd0, prev_pixel};
  assign set_a[1] = prev_r;
  assign set_a[2] = prev_g;
  assign set_a[3] = prev_b;
  assign set_b[0] = {8'd0, px_in};
  assign set_b[1] = cmd.red_in;
  assign set_b[2] = cmd.green_in;
  assign set_b[3] = cmd.blue_in;

  // divide: shift the next dividend bit in; accumulate: add the remainder step
  assign step_x = (state == S_DIV) ? {rem, dq[15]}
                                   : ({1'b0, accr[lane]} + {1'b0, r0[lane]});

  prl_step u_step (
    .x    (step_x),
    .span (span),
    .res  (step_res)
  );

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lane_val[l] = neg[l] ? (base[l] - accq[l]) : (base[l] + accq[l]);
    end
    fill_entry.pixel = lane_val[0][7:0];
    fill_entry.red   = lane_val[1];
    fill_entry.green = lane_val[2];
    fill_entry.blue  = lane_val[3];
  end

  assign push_en    = ((state == S_FILL) || (state == S_APPEND)) && !full;
  assign push_entry = (state == S_FILL) ? fill_entry : pt;

  prl_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (cells[AW-1:0]),
    .wr_data (push_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    rsp_next.status      = st;
    rsp_next.cell_count  = cells_w[8:0];
    rsp_next.entry_valid = rd_valid;
    rsp_next.entry_pixel = rd_valid ? rd_data.pixel : 8'd0;
    rsp_next.entry_red   = rd_valid ? rd_data.red   : 16'd0;
    rsp_next.entry_green = rd_valid ? rd_data.green : 16'd0;
    rsp_next.entry_blue  = rd_valid ? rd_data.blue  : 16'd0;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cells      <= '0;
      prev_pixel <= 8'd0;
      prev_r     <= 16'd0;
      prev_g     <= 16'd0;
      prev_b     <= 16'd0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (push_en) begin
        cells <= cells + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.func)
              prl_pkg::FN_ADD:   state <= ramp_ok ? S_DIV : S_APPEND;
              prl_pkg::FN_READ:  state <= S_READ;
              prl_pkg::FN_CLEAR: begin
                cells <= '0;
                state <= S_DONE;
              end
              default:           state <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          if (bitcnt == 4'd15 && lane == 2'd3) begin
            state <= (span == 8'd1) ? S_APPEND : S_ACC;
          end
        end
        S_ACC: begin
          if (lane == 2'd3) begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          state <= ((k + 8'd1) == span) ? S_APPEND : S_ACC;
        end
        S_APPEND: begin
          prev_pixel <= pt.pixel;
          prev_r     <= pt.red;
          prev_g     <= pt.green;
          prev_b     <= pt.blue;
          state      <= S_DONE;
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (push_en) begin
      last_pixel <= push_entry.pixel;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pt.pixel <= px_in;
          pt.red   <= cmd.red_in;
          pt.green <= cmd.green_in;
          pt.blue  <= cmd.blue_in;
          dropped  <= 1'b0;
          rd_addr  <= idx_w[AW-1:0];
          rd_valid <= (cmd.func == prl_pkg::FN_READ) && (idx_w < cells_w);
          span     <= px_in - last_pixel;
          lane     <= 2'd0;
          bitcnt   <= 4'd0;
          rem      <= 8'd0;
          dq       <= (set_b[0] < set_a[0]) ? (set_a[0] - set_b[0])
                                            : (set_b[0] - set_a[0]);
          for (int l = 0; l < 4; l++) begin
            base[l] <= set_a[l];
            neg[l]  <= (set_b[l] < set_a[l]);
            mag[l]  <= (set_b[l] < set_a[l]) ? (set_a[l] - set_b[l])
                                             : (set_b[l] - set_a[l]);
          end
          if (cmd.func == prl_pkg::FN_ADD && cmd.ramp_before && cells == '0) begin
            st <= prl_pkg::ST_EMPTY;
          end else if (cmd.func == prl_pkg::FN_ADD && cmd.ramp_before &&
                       px_in <= last_pixel) begin
            st <= prl_pkg::ST_SPAN;
          end else begin
            st <= prl_pkg::ST_OK;
          end
        end
      end
      S_DIV: begin
        bitcnt <= bitcnt + 4'd1;
        if (bitcnt == 4'd15) begin
          q0[lane]   <= {dq[14:0], step_res.ge};
          r0[lane]   <= step_res.rest[7:0];
          accq[lane] <= 16'd0;
          accr[lane] <= 8'd0;
          rem        <= 8'd0;
          lane       <= lane + 2'd1;
          k          <= 8'd1;
          dq         <= mag[lane + 2'd1];
        end else begin
          dq  <= {dq[14:0], step_res.ge};
          rem <= step_res.rest[7:0];
        end
      end
      S_ACC: begin
        accr[lane] <= step_res.rest[7:0];
        accq[lane] <= accq[lane] + q0[lane] + 16'(step_res.ge);
        lane       <= lane + 2'd1;
      end
      S_FILL: begin
        if (full) begin
          dropped <= 1'b1;
        end
        k <= k + 8'd1;
      end
      S_APPEND: begin
        if (dropped || full) begin
          st <= prl_pkg::ST_FULL;
        end
      end
      S_READ: begin
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/prl_check.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prl_check (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cmd_valid,
  input wire logic           cmd_stall,
  input wire prl_pkg::cmd_t  cmd,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire prl_pkg::rsp_t  rsp
);

  // leave reset idle and ready
  a_reset_idle: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!rsp_valid && !cmd_stall))
    else $error("not idle after reset");

  // an accepted beat keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("ready straight after accepting a beat");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result beat changed");

  a_valid_entry_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.entry_valid) |-> (rsp.status == prl_pkg::ST_OK))
    else $error("read beat with non-ok status");

  a_empty_entry_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.entry_valid) |->
      (rsp.entry_pixel == 8'd0 && rsp.entry_red == 16'd0 &&
       rsp.entry_green == 16'd0 && rsp.entry_blue == 16'd0))
    else $error("entry fields set without a valid entry");

endmodule

bind palette_ramp_loader_unit prl_check u_prl_check (.*);

`default_nettype wire

@@ tb/tb_palette_ramp_loader_unit.sv @@
`timescale 1ns / 1ps

module tb_palette_ramp_loader_unit;

  localparam int DEPTH        = prl_pkg::TABLE_DEPTH_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 64;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  prl_pkg::cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  prl_pkg::rsp_t rsp;

  // palette as the block should hold it
  prl_pkg::entry_t pal_tab [DEPTH];
  int              pal_count  = 0;
  prl_pkg::entry_t last_point = '0;

  prl_pkg::rsp_t awaited_results [$];
  int            err_count = 0;

  int send_idle_pct = 0;
  int rcv_idle_pct  = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int walk_px       = -1;

  palette_ramp_loader_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  function automatic longint ramp_point(input longint a, input longint b, input longint k,
                                        input longint span);
    return a + ((b - a) * k) / span;
  endfunction

  function automatic bit store_entry(input prl_pkg::entry_t e);
    if (pal_count >= DEPTH) return 1'b0;
    pal_tab[pal_count] = e;
    pal_count++;
    return 1'b1;
  endfunction

  function automatic prl_pkg::rsp_t predict_palette(input prl_pkg::cmd_t c);
    prl_pkg::rsp_t   r;
    prl_pkg::entry_t pt;
    prl_pkg::entry_t fill;
    longint          span;
    longint          k;
    bit              dropped;
    r = '0;
    dropped = 1'b0;
    case (c.func)
      prl_pkg::FN_ADD: begin
        pt.pixel = c.color_number[7:0];
        pt.red   = c.red_in;
        pt.green = c.green_in;
        pt.blue  = c.blue_in;
        if (c.ramp_before) begin
          if (pal_count == 0) begin
            r.status = prl_pkg::ST_EMPTY;
          end else begin
            // span runs from the last stored entry, the ramp from the last point
            span = longint'(pt.pixel) - longint'(pal_tab[pal_count - 1].pixel);
            if (span <= 0) begin
              r.status = prl_pkg::ST_SPAN;
            end else begin
              for (k = 1; k < span; k++) begin
                fill.pixel = 8'(ramp_point(last_point.pixel, pt.pixel, k, span));
                fill.red   = 16'(ramp_point(last_point.red, pt.red, k, span));
                fill.green = 16'(ramp_point(last_point.green, pt.green, k, span));
                fill.blue  = 16'(ramp_point(last_point.blue, pt.blue, k, span));
                if (!store_entry(fill)) dropped = 1'b1;
              end
            end
          end
        end
        if (!store_entry(pt)) dropped = 1'b1;
        if (dropped) r.status = prl_pkg::ST_FULL;
        last_point = pt;
      end
      prl_pkg::FN_READ: begin
        if (c.read_index < pal_count) begin
          r.entry_valid = 1'b1;
          r.entry_pixel = pal_tab[c.read_index].pixel;
          r.entry_red   = pal_tab[c.read_index].red;
          r.entry_green = pal_tab[c.read_index].green;
          r.entry_blue  = pal_tab[c.read_index].blue;
        end
      end
      prl_pkg::FN_CLEAR: pal_count = 0;
      default: ;
    endcase
    r.cell_count = 9'(pal_count);
    return r;
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got)
      report_error($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  // watch both channels; predict on each command beat, check on each result beat
  always @(posedge clk) begin : watch
    prl_pkg::rsp_t want;
    if (!rst) begin
      if (cmd_valid && cmd_stall === 1'b0) awaited_results.push_back(predict_palette(cmd));
      if (rsp_valid === 1'b1 && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          report_error("result beat with nothing awaited");
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", want.status, rsp.status);
          compare_field("cell_count", want.cell_count, rsp.cell_count);
          compare_field("entry_valid", want.entry_valid, rsp.entry_valid);
          compare_field("entry_pixel", want.entry_pixel, rsp.entry_pixel);
          compare_field("entry_red", want.entry_red, rsp.entry_red);
          compare_field("entry_green", want.entry_green, rsp.entry_green);
          compare_field("entry_blue", want.entry_blue, rsp.entry_blue);
        end
      end
    end
  end

  // result side: random stall, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99, 0) < rcv_idle_pct);
    end
  end

  task automatic send_cmd(input prl_pkg::cmd_t c);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall !== 1'b0);
  endtask

  function automatic prl_pkg::cmd_t make_cmd(input prl_pkg::func_t f,
                                             input logic [15:0] colour,
                                             input logic [15:0] red,
                                             input logic [15:0] green,
                                             input logic [15:0] blue, input logic ramp,
                                             input logic [7:0] idx);
    prl_pkg::cmd_t c;
    c.func         = f;
    c.color_number = colour;
    c.red_in       = red;
    c.green_in     = green;
    c.blue_in      = blue;
    c.ramp_before  = ramp;
    c.read_index   = idx;
    return c;
  endfunction

  function automatic prl_pkg::cmd_t random_cmd();
    prl_pkg::cmd_t c;
    c.func         = prl_pkg::func_t'($urandom_range(2, 0));
    c.color_number = 16'($urandom);
    c.red_in       = 16'($urandom);
    c.green_in     = 16'($urandom);
    c.blue_in      = 16'($urandom);
    c.ramp_before  = 1'($urandom);
    c.read_index   = 8'($urandom);
    return c;
  endfunction

  task automatic add_point(input logic [15:0] colour, input logic [15:0] red,
                           input logic [15:0] green, input logic [15:0] blue,
                           input logic ramp);
    send_cmd(make_cmd(prl_pkg::FN_ADD, colour, red, green, blue, ramp, 8'h00));
  endtask

  task automatic read_entry(input logic [7:0] idx);
    send_cmd(make_cmd(prl_pkg::FN_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                      idx));
  endtask

  task automatic clear_table();
    send_cmd(make_cmd(prl_pkg::FN_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                      8'h00));
  endtask

  task automatic test_empty_table();
    read_entry(8'h00);
    // high byte of the colour number must be ignored
    add_point(16'hFF05, 16'hFFFF, 16'h0000, 16'h8000, 1'b1);
  endtask

  task automatic test_ramp_fill();
    // falling red checks truncation toward zero
    add_point(16'h0009, 16'h0000, 16'hFFFF, 16'h8003, 1'b1);
    read_entry(8'h01);
    read_entry(8'h02);
    read_entry(8'h04);
    read_entry(8'hFF);
  endtask

  task automatic test_bad_span();
    add_point(16'h0009, 16'h1234, 16'h5678, 16'h9ABC, 1'b1);
    add_point(16'h0102, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
  endtask

  task automatic test_clear_keeps_point();
    clear_table();
    read_entry(8'h00);
    add_point(16'h0010, 16'h0F0F, 16'hF0F0, 16'h00FF, 1'b1);
  endtask

  task automatic test_table_full();
    clear_table();
    add_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_point(16'h00FA, 16'hFFFF, 16'h0000, 16'h8000, 1'b1);
    add_point(16'h7F00, 16'h1234, 16'hFFFF, 16'h0001, 1'b0);
    // fill overruns the depth part way through
    add_point(16'h000A, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    read_entry(8'hFF);
    read_entry(8'hFB);
    add_point(16'h00FF, 16'hAAAA, 16'h5555, 16'hFFFF, 1'b0);
    add_point(16'h0003, 16'h0001, 16'h0002, 16'h0003, 1'b1);
    clear_table();
  endtask

  task automatic test_output_backpressure();
    hold_reqs++;
    add_point(16'h0020, 16'h1111, 16'h2222, 16'h3333, 1'b0);
    add_point(16'h0024, 16'hEEEE, 16'h0001, 16'h3330, 1'b1);
    read_entry(8'h01);
    read_entry(8'h02);
    read_entry(8'h40);
    clear_table();
  endtask

  // mostly rising runs of ramped points with random colours, mixed with reads and noise
  task automatic test_random_walk(input int n_items);
    prl_pkg::cmd_t c;
    int            pick;
    int            step;
    for (int i = 0; i < n_items; i++) begin
      c    = random_cmd();
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        if (walk_px > 245) begin
          c.func = prl_pkg::FN_CLEAR;
        end else if (walk_px < 0) begin
          c.func = prl_pkg::FN_ADD;
          c.ramp_before = 1'b0;
          c.color_number[7:0] = 8'($urandom_range(40, 0));
        end else begin
          step = ($urandom_range(11, 0) == 0) ? $urandom_range(255 - walk_px, 1)
                                              : $urandom_range(10, 1);
          c.func = prl_pkg::FN_ADD;
          c.ramp_before = 1'b1;
          c.color_number[7:0] = 8'(walk_px + step);
        end
      end else if (pick < 75) begin
        c.func = prl_pkg::FN_READ;
        if ($urandom_range(1, 0) == 1) c.read_index = 8'($urandom_range(31, 0));
      end else if (pick < 83) begin
        c.func = prl_pkg::FN_ADD;
        c.ramp_before = 1'b0;
      end else if (pick < 90 && walk_px >= 0) begin
        // repeat or step back
        c.func = prl_pkg::FN_ADD;
        c.ramp_before = 1'b1;
        c.color_number[7:0] = 8'($urandom_range(walk_px, 0));
      end else if (pick < 94) begin
        c.func = prl_pkg::FN_CLEAR;
      end
      if (c.func == prl_pkg::FN_CLEAR) walk_px = -1;
      else if (c.func == prl_pkg::FN_ADD) walk_px = c.color_number[7:0];
      send_cmd(c);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 23;
    rcv_idle_pct  = 84;
    test_empty_table();
    test_ramp_fill();
    test_bad_span();
    test_clear_keeps_point();
    test_table_full();
    test_random_walk(40);

    send_idle_pct = 84;
    rcv_idle_pct  = 23;
    test_random_walk(40);

    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    test_output_backpressure();
    test_random_walk(40);

    @(negedge clk);
    cmd_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
